// ===== rtl/ppq_pkg.sv =====
// Shared types and codes for the priority process queue.
package ppq_pkg;

  // Operation codes carried on in_kind
  localparam logic [1:0] KIND_APPEND   = 2'd0;
  localparam logic [1:0] KIND_INSERT   = 2'd1;
  localparam logic [1:0] KIND_POP_HEAD = 2'd2;
  localparam logic [1:0] KIND_POP_BEST = 2'd3;

  // One stored process entry
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pri;
    logic [15:0] exec_time;
  } entry_t;

  // Command applied to every cell in the same cycle
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_APPEND,
    CMD_POP_HEAD,
    CMD_INSERT,
    CMD_REMOVE
  } cell_cmd_t;

  // What a search token does as it walks the chain
  typedef enum logic [1:0] {
    SW_INSERT,
    SW_MAX,
    SW_SELECT
  } sweep_mode_t;

  // Broadcast control from the sequencer to all cells
  typedef struct packed {
    cell_cmd_t   cmd;
    sweep_mode_t mode;
    entry_t      new_entry;
  } cell_ctrl_t;

  // Contents a cell shows to its neighbors
  typedef struct packed {
    logic   valid;
    logic   after;
    entry_t data;
  } cell_link_t;

  // Search token handed from cell to cell, one hop per cycle
  typedef struct packed {
    logic   act;
    logic   found;
    logic [7:0] key;
    entry_t data;
  } sweep_t;

endpackage

// ===== rtl/ppq_cell.sv =====
// One queue slot: stored entry, search token stage and shift logic.
module ppq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ppq_pkg::cell_ctrl_t ctrl,
  input  ppq_pkg::cell_link_t prev_i,
  input  ppq_pkg::cell_link_t next_i,
  input  ppq_pkg::sweep_t     sw_i,
  output ppq_pkg::cell_link_t link_o,
  output ppq_pkg::sweep_t     sw_o
);

  logic            valid_r, valid_nxt;
  logic            after_r;
  ppq_pkg::entry_t data_r, data_nxt;
  ppq_pkg::sweep_t sw_r, sw_nxt;
  logic            mark;
  logic            lower;
  logic            match;

  // Evaluate the passing token against this slot
  always_comb begin
    lower  = valid_r && (data_r.pri < sw_i.key);
    match  = valid_r && (data_r.pri == sw_i.key);
    case (ctrl.mode)
      ppq_pkg::SW_INSERT: mark = !sw_i.found && (!valid_r || lower);
      ppq_pkg::SW_SELECT: mark = !sw_i.found && match;
      default:            mark = 1'b0;
    endcase
    sw_nxt       = sw_i;
    sw_nxt.found = sw_i.found || mark;
    if (mark) begin
      sw_nxt.data = data_r;
    end
    if (ctrl.mode == ppq_pkg::SW_MAX && valid_r && data_r.pri > sw_i.key) begin
      sw_nxt.key = data_r.pri;
    end
  end

  // Apply the broadcast command using neighbor contents and the broadcast entry
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    case (ctrl.cmd)
      ppq_pkg::CMD_APPEND: begin
        if (!valid_r && prev_i.valid) begin
          valid_nxt = 1'b1;
          data_nxt  = ctrl.new_entry;
        end
      end
      ppq_pkg::CMD_POP_HEAD: begin
        valid_nxt = next_i.valid;
        data_nxt  = next_i.data;
      end
      ppq_pkg::CMD_INSERT: begin
        if (after_r && !prev_i.after) begin
          valid_nxt = 1'b1;
          data_nxt  = ctrl.new_entry;
        end else if (after_r) begin
          valid_nxt = prev_i.valid;
          data_nxt  = prev_i.data;
        end
      end
      ppq_pkg::CMD_REMOVE: begin
        if (after_r) begin
          valid_nxt = next_i.valid;
          data_nxt  = next_i.data;
        end
      end
      default: begin
        valid_nxt = valid_r;
        data_nxt  = data_r;
      end
    endcase
  end

  // Hold control state and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      after_r  <= 1'b0;
      sw_r.act <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      sw_r.act <= sw_nxt.act;
      if (sw_i.act) begin
        after_r <= sw_nxt.found;
      end
    end
    data_r     <= data_nxt;
    sw_r.found <= sw_nxt.found;
    sw_r.key   <= sw_nxt.key;
    sw_r.data  <= sw_nxt.data;
  end

  assign link_o.valid = valid_r;
  assign link_o.after = after_r;
  assign link_o.data  = data_r;
  assign sw_o         = sw_r;

endmodule

// ===== rtl/priority_process_queue.sv =====
// Top level: ordered process queue built from a chain of slot cells.
//
//   channel  direction  handshake            ports
//   in       input      start high, busy low in_kind, in_process_id, in_priority_req, in_exec_time
//   out      output     out_valid, 1 cycle   out_found, out_rejected_full, out_id,
//                                            out_priority, out_time, out_occupancy
//
// Append, pop head, and any rejected or empty operation: result the next cycle.
// Sorted insert: one search token walks the chain one slot per cycle.
// Pop best: one walk finds the top priority, a second finds its slot.
// Reset (rst_n low, synchronous) empties the queue; slot contents stay undefined.
// The result strobe cannot be stalled; busy is low whenever a result is shown.
module priority_process_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_process_id,
  input  logic [7:0]  in_priority_req,
  input  logic [15:0] in_exec_time,
  output logic        out_valid,
  output logic        out_found,
  output logic        out_rejected_full,
  output logic [15:0] out_id,
  output logic [7:0]  out_priority,
  output logic [15:0] out_time,
  output logic [4:0]  out_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SWEEP
  } state_t;

  state_t                state_r, state_nxt;
  ppq_pkg::sweep_mode_t  mode_r, mode_nxt;
  logic                  inject_r, inject_nxt;
  logic [7:0]            key_r, key_nxt;
  ppq_pkg::entry_t       new_r, new_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic                  out_rej_r, out_rej_nxt;
  ppq_pkg::entry_t       out_data_r, out_data_nxt;
  logic [4:0]            out_occ_r, out_occ_nxt;
  logic [CW+4:0]         occ_ext;
  logic                  full;
  logic                  empty;
  ppq_pkg::cell_ctrl_t   ctrl;
  ppq_pkg::cell_link_t   link    [DEPTH];
  ppq_pkg::cell_link_t   prev_in [DEPTH];
  ppq_pkg::cell_link_t   next_in [DEPTH];
  ppq_pkg::sweep_t       sw_out  [DEPTH];
  ppq_pkg::sweep_t       sw_in   [DEPTH];
  ppq_pkg::sweep_t       sw_end;
  ppq_pkg::entry_t       in_entry;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign sw_end   = sw_out[DEPTH-1];
  assign in_entry = '{id: in_process_id, pri: in_priority_req, exec_time: in_exec_time};

  // Chain of cells with neighbor links and token hand-off
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_in[i] = '{valid: 1'b1, after: 1'b0, data: '0};
      assign sw_in[i].act   = inject_r;
      assign sw_in[i].found = 1'b0;
      assign sw_in[i].key   = (mode_r == ppq_pkg::SW_MAX) ? 8'd0 :
                              (mode_r == ppq_pkg::SW_SELECT) ? key_r : new_r.pri;
      assign sw_in[i].data  = '0;
    end else begin : g_body
      assign prev_in[i] = link[i-1];
      assign sw_in[i]   = sw_out[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_in[i] = '{valid: 1'b0, after: 1'b0, data: '0};
    end else begin : g_inner
      assign next_in[i] = link[i+1];
    end

    ppq_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .prev_i (prev_in[i]),
      .next_i (next_in[i]),
      .sw_i   (sw_in[i]),
      .link_o (link[i]),
      .sw_o   (sw_out[i])
    );
  end

  // Decode the word and sequence the searches
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    inject_nxt     = 1'b0;
    key_nxt        = key_r;
    new_nxt        = new_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = 1'b0;
    out_rej_nxt    = 1'b0;
    out_data_nxt   = '0;
    ctrl.cmd       = ppq_pkg::CMD_HOLD;
    ctrl.mode      = mode_r;
    ctrl.new_entry = new_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          case (in_kind)
            ppq_pkg::KIND_APPEND: begin
              if (full) begin
                out_rej_nxt = 1'b1;
              end else begin
                ctrl.cmd       = ppq_pkg::CMD_APPEND;
                ctrl.new_entry = in_entry;
                count_nxt      = count_r + CW'(1);
                out_found_nxt  = 1'b1;
              end
            end
            ppq_pkg::KIND_INSERT: begin
              if (full) begin
                out_rej_nxt = 1'b1;
              end else begin
                out_valid_nxt = 1'b0;
                new_nxt       = in_entry;
                mode_nxt      = ppq_pkg::SW_INSERT;
                inject_nxt    = 1'b1;
                state_nxt     = ST_SWEEP;
              end
            end
            ppq_pkg::KIND_POP_HEAD: begin
              if (!empty) begin
                ctrl.cmd      = ppq_pkg::CMD_POP_HEAD;
                count_nxt     = count_r - CW'(1);
                out_found_nxt = 1'b1;
                out_data_nxt  = link[0].data;
              end
            end
            default: begin
              if (!empty) begin
                out_valid_nxt = 1'b0;
                mode_nxt      = ppq_pkg::SW_MAX;
                inject_nxt    = 1'b1;
                state_nxt     = ST_SWEEP;
              end
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (sw_end.act) begin
          case (mode_r)
            ppq_pkg::SW_MAX: begin
              key_nxt    = sw_end.key;
              mode_nxt   = ppq_pkg::SW_SELECT;
              inject_nxt = 1'b1;
            end
            ppq_pkg::SW_INSERT: begin
              ctrl.cmd      = ppq_pkg::CMD_INSERT;
              count_nxt     = count_r + CW'(1);
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
            default: begin
              ctrl.cmd      = ppq_pkg::CMD_REMOVE;
              count_nxt     = count_r - CW'(1);
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b1;
              out_data_nxt  = sw_end.data;
              state_nxt     = ST_IDLE;
            end
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Occupancy field is the count taken to five bits
  assign occ_ext     = {5'b0, count_nxt};
  assign out_occ_nxt = occ_ext[4:0];

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= ppq_pkg::SW_INSERT;
      inject_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      inject_r    <= inject_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r       <= key_nxt;
    new_r       <= new_nxt;
    out_found_r <= out_found_nxt;
    out_rej_r   <= out_rej_nxt;
    out_data_r  <= out_data_nxt;
    out_occ_r   <= out_occ_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_rejected_full = out_rej_r;
  assign out_id            = out_data_r.id;
  assign out_priority      = out_data_r.pri;
  assign out_time          = out_data_r.exec_time;
  assign out_occupancy     = out_occ_r;

  // A result word only appears once the sequencer is back to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  // A word never reports both success and rejection
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_rejected_full)) else $error("found and rejected");

  // Count never exceeds the number of slots
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("count overflow");

  // Rejection only happens with every slot taken
  a_rej_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected_full |-> full) else $error("reject while not full");

  // Append and pop head show their result in the next cycle
  a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind == ppq_pkg::KIND_APPEND || in_kind == ppq_pkg::KIND_POP_HEAD)
    |=> out_valid) else $error("fast op result missing");

endmodule
